// ----- src/cwk_pkg.sv -----
package cwk_pkg;

	localparam int OP_DEPTH_DEF  = 4;
	localparam int RES_DEPTH_DEF = 2;

	// input modes
	localparam logic [1:0] MODE_HOST    = 2'd0;
	localparam logic [1:0] MODE_BUSY    = 2'd1;
	localparam logic [1:0] MODE_BREAKIN = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_HOST  = 2'd0;
	localparam logic [1:0] KIND_SPEED = 2'd1;
	localparam logic [1:0] KIND_PTT   = 2'd2;

	// parameter awaited by the back end
	localparam logic [2:0] PEND_NONE   = 3'd0;
	localparam logic [2:0] PEND_ADMIN  = 3'd1;
	localparam logic [2:0] PEND_IGNORE = 3'd2;
	localparam logic [2:0] PEND_SPEED  = 3'd3;
	localparam logic [2:0] PEND_PTT    = 3'd4;

	// command class found by the front end
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_ADMIN  = 3'd1;
	localparam logic [2:0] CMD_IGNORE = 3'd2;
	localparam logic [2:0] CMD_SPEED  = 3'd3;
	localparam logic [2:0] CMD_PTT    = 3'd4;
	localparam logic [2:0] CMD_STATUS = 3'd5;
	localparam logic [2:0] CMD_CLEAR  = 3'd6;

	// host command bytes
	localparam logic [7:0] HC_ADMIN      = 8'h00;
	localparam logic [7:0] HC_SIDETONE   = 8'h01;
	localparam logic [7:0] HC_SPEED      = 8'h02;
	localparam logic [7:0] HC_WEIGHT     = 8'h03;
	localparam logic [7:0] HC_PTT        = 8'h04;
	localparam logic [7:0] HC_PAUSE      = 8'h07;
	localparam logic [7:0] HC_BUF_SPEED  = 8'h0B;
	localparam logic [7:0] HC_BUF_PTT    = 8'h0C;
	localparam logic [7:0] HC_NULL       = 8'h0F;
	localparam logic [7:0] HC_STATUS_REQ = 8'h11;
	localparam logic [7:0] HC_CLEAR_BUF  = 8'h15;

	// admin parameters
	localparam logic [7:0] ADM_OPEN  = 8'h02;
	localparam logic [7:0] ADM_CLOSE = 8'h03;

	localparam logic [7:0] VERSION_BYTE = 8'd31;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       flag;
		logic [2:0] cmd;
	} op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} res_t;

	// bit 2 is the wait flag, always clear
	function automatic logic [7:0] status_byte(input logic busy, input logic breakin);
		status_byte = {5'b0, 1'b0, busy, breakin};
	endfunction

endpackage

// ----- src/cwk_fifo.sv -----
module cwk_fifo import cwk_pkg::*; #(
	parameter int WIDTH = $bits(op_t),
	parameter int DEPTH = OP_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- src/cwk_front.sv -----
module cwk_front import cwk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	input  logic       flag_value,
	output logic       op_push,
	output op_t        op,
	input  logic       op_full
);

	logic valid_s1;
	op_t  op_s1;
	logic take;
	logic [2:0] cmd;

	// command class of the byte, used by the back end only when nothing is pending
	always_comb begin
		cmd = CMD_NONE;
		if (mode == MODE_HOST) begin
			case (data_byte)
				HC_ADMIN:                            cmd = CMD_ADMIN;
				HC_SIDETONE, HC_WEIGHT, HC_PAUSE:    cmd = CMD_IGNORE;
				HC_SPEED, HC_BUF_SPEED:              cmd = CMD_SPEED;
				HC_PTT, HC_BUF_PTT:                  cmd = CMD_PTT;
				HC_NULL, HC_STATUS_REQ:              cmd = CMD_STATUS;
				HC_CLEAR_BUF:                        cmd = CMD_CLEAR;
				default:                             cmd = CMD_NONE;
			endcase
		end
	end

	assign op_push = valid_s1 && !op_full;
	assign op      = op_s1;
	assign full    = valid_s1 && op_full;
	assign take    = push && !full;

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= '{mode: mode, data: data_byte, flag: flag_value, cmd: cmd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (op_push) begin
			valid_s1 <= 1'b0;
		end
	end

endmodule

// ----- src/cwk_back.sv -----
module cwk_back import cwk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_empty,
	input  op_t  op,
	output logic op_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);

	logic [2:0] pend_q, pend_d;
	logic       open_q, open_d;
	logic       busy_q, busy_d;
	logic       brk_q, brk_d;
	logic       sec_q, sec_d;

	always_comb begin
		pend_d   = pend_q;
		open_d   = open_q;
		busy_d   = busy_q;
		brk_d    = brk_q;
		sec_d    = sec_q;
		op_pop   = 1'b0;
		res_push = 1'b0;
		res      = '{kind: KIND_HOST, value: status_byte(busy_q, brk_q), last: 1'b1};
		if (sec_q) begin
			// status byte that follows the version after an admin open
			if (!res_full) begin
				res_push = 1'b1;
				sec_d    = 1'b0;
			end
		end else if (!op_empty && !res_full) begin
			op_pop = 1'b1;
			case (op.mode)
				MODE_HOST: begin
					if (pend_q != PEND_NONE) begin
						pend_d = PEND_NONE;
						case (pend_q)
							PEND_ADMIN: begin
								res_push = 1'b1;
								if (op.data == ADM_OPEN) begin
									open_d = 1'b1;
									sec_d  = 1'b1;
									res    = '{kind: KIND_HOST, value: VERSION_BYTE, last: 1'b0};
								end else if (op.data == ADM_CLOSE) begin
									open_d = 1'b0;
								end
							end
							PEND_SPEED: begin
								res_push = 1'b1;
								res      = '{kind: KIND_SPEED, value: op.data, last: 1'b1};
							end
							PEND_PTT: begin
								res_push = 1'b1;
								res      = '{kind: KIND_PTT, value: {7'b0, op.data[0]}, last: 1'b1};
							end
							default: ;
						endcase
					end else begin
						case (op.cmd)
							CMD_ADMIN:  pend_d = PEND_ADMIN;
							CMD_IGNORE: pend_d = PEND_IGNORE;
							CMD_SPEED:  pend_d = PEND_SPEED;
							CMD_PTT:    pend_d = PEND_PTT;
							CMD_STATUS: res_push = 1'b1;
							CMD_CLEAR: begin
								busy_d   = 1'b0;
								res_push = 1'b1;
								res.value = status_byte(1'b0, brk_q);
							end
							default: ;
						endcase
					end
				end
				MODE_BUSY: begin
					busy_d    = op.flag;
					res_push  = open_q;
					res.value = status_byte(op.flag, brk_q);
				end
				MODE_BREAKIN: begin
					brk_d = op.flag;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_NONE;
			open_q <= 1'b0;
			busy_q <= 1'b0;
			brk_q  <= 1'b0;
			sec_q  <= 1'b0;
		end else begin
			pend_q <= pend_d;
			open_q <= open_d;
			busy_q <= busy_d;
			brk_q  <= brk_d;
			sec_q  <= sec_d;
		end
	end

`ifndef SYNTHESIS
	a_sec_open: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q |-> open_q)
		else $error("second admin result pending while host closed");

	a_sec_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q |-> !op_pop)
		else $error("op taken while a result is still owed");

	a_sec_after_version: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sec_q) |-> $past(res_push && res.value == VERSION_BYTE && !res.last))
		else $error("status follow-up without version byte");

	a_ptt_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res.kind == KIND_PTT) |-> (res.value[7:1] == 7'b0))
		else $error("ptt result with stray bits");
`endif

endmodule

// ----- src/cw_keyer_host_command_parser.sv -----
// host command parser for a morse keyer
// input side is a queue: drive mode, data_byte and flag_value with push; a transfer
// happens on a clock edge with push high and full low. mode 0 carries a host byte,
// mode 1 sets the busy flag, mode 2 sets the breakin flag.
// result side is a queue: while empty is low the oldest result sits on out_kind,
// out_value and out_last; pop high on an edge takes it. out_last marks the final
// result of an input; an input may give zero, one or two results.
// with nothing stalled, an input transfer loads the front register, the command
// queue takes it from there, and the back end then writes its results into the
// result queue, where they become visible.
// throughput: one input per cycle when nothing stalls; an admin open holds the back
// end off the command queue since it emits two results, one per cycle when not stalled.
// a stalled receiver fills the result queue, then the back end stops, the command
// queue fills and full rises; no result is lost or reordered.
// reset clears all flags, the pending command and both queues; no clearing pass.
module cw_keyer_host_command_parser import cwk_pkg::*; #(
	parameter int OP_DEPTH  = OP_DEPTH_DEF,
	parameter int RES_DEPTH = RES_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] mode,
	input  logic [7:0] data_byte,
	input  logic       flag_value,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] out_kind,
	output logic [7:0] out_value,
	output logic       out_last
);

	logic op_push;
	logic op_full;
	logic op_empty;
	logic op_pop;
	op_t  op_in;
	op_t  op_out;
	logic res_push;
	logic res_full;
	res_t res_in;
	res_t res_out;

	cwk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.data_byte  (data_byte),
		.flag_value (flag_value),
		.op_push    (op_push),
		.op         (op_in),
		.op_full    (op_full)
	);

	cwk_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (OP_DEPTH)
	) u_op_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_in),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_out),
		.empty  (op_empty)
	);

	cwk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op       (op_out),
		.op_pop   (op_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	cwk_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign out_kind  = res_out.kind;
	assign out_value = res_out.value;
	assign out_last  = res_out.last;

endmodule
